>>> rtl/eirc_pkg.sv
// ----------------------------------------------------------------------------
// eirc_pkg
// Shared constants, verdict codes and inter-module types of the Ethernet /
// IPv4 receive classifier.
// ----------------------------------------------------------------------------
package eirc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF     = 2;

  localparam int ETH_HDR    = 14;
  localparam int IP_MIN_HDR = 20;

  localparam int IPLEN_W = 16;
  localparam int FLEN_W  = 12;
  localparam int POFF_W  = 7;
  localparam int PLEN_W  = 12;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [1:0] REG_OWN_MAC   = 2'd0;
  localparam logic [1:0] REG_OWN_IP    = 2'd1;
  localparam logic [1:0] REG_IF_ENABLE = 2'd2;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  BYTE_ONES   = 8'hFF;
  localparam logic [15:0] CSUM_GOOD   = 16'hFFFF;
  localparam logic [31:0] IP_BCAST    = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    V_SHORT,
    V_MAC_MISS,
    V_ARP,
    V_OTHER_TYPE,
    V_BAD_VERSION,
    V_BAD_HLEN,
    V_BAD_TLEN,
    V_BAD_CSUM,
    V_NOT_OURS,
    V_ICMP,
    V_UDP,
    V_TCP,
    V_UNKNOWN
  } verdict_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic        if_enable;
  } cfg_t;

  typedef struct packed {
    logic               short_frame;
    logic [FLEN_W-1:0]  byte_cnt;
    logic [IPLEN_W-1:0] ip_len;
    logic               mac_ok;
    logic [15:0]        frame_type;
    logic [47:0]        src_mac;
    logic [7:0]         version_ihl;
    logic [15:0]        ip_tot_len;
    logic [15:0]        csum;
    logic [31:0]        dst_ip;
    logic [31:0]        src_ip;
    logic [7:0]         protocol;
  } frame_sum_t;

endpackage

>>> rtl/eirc_in_if.sv
// ----------------------------------------------------------------------------
// eirc_in_if
// Frame byte channel: valid/ready handshake with byte and last-byte mark.
// ----------------------------------------------------------------------------
interface eirc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       end_of_frame;

  modport source (output valid, output frame_byte, output end_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

>>> rtl/eirc_out_if.sv
// ----------------------------------------------------------------------------
// eirc_out_if
// Verdict channel: valid/ready handshake with one classification per frame.
// ----------------------------------------------------------------------------
interface eirc_out_if;
  import eirc_pkg::*;

  logic               valid;
  logic               ready;
  verdict_t           verdict;
  logic               learn_valid;
  logic [31:0]        source_ip;
  logic [47:0]        source_mac;
  logic [POFF_W-1:0]  payload_offset;
  logic [PLEN_W-1:0]  payload_length;
  logic [FLEN_W-1:0]  frame_length;

  modport source (output valid, output verdict, output learn_valid, output source_ip,
                  output source_mac, output payload_offset, output payload_length,
                  output frame_length, input ready);
  modport sink   (input valid, input verdict, input learn_valid, input source_ip,
                  input source_mac, input payload_offset, input payload_length,
                  input frame_length, output ready);
endinterface

>>> rtl/eth_ipv4_rx_classifier_unit.sv
// ----------------------------------------------------------------------------
// eth_ipv4_rx_classifier_unit
// Ethernet / IPv4 receive header classifier: one verdict per frame received while enabled.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while the summary queue is not full, set by the byte parser's field update.
// The summary of a frame is written into the summary queue when its last byte is
//   accepted, then loaded into the verdict output register once that register is free.
// The summary queue holds QUEUE_DEPTH frames; input stalls only when it is full.
// Reset: synchronous, active low; configuration clears to zero (interface off),
//   frame state returns to idle, queue empties.
// ----------------------------------------------------------------------------
module eth_ipv4_rx_classifier_unit #(
  parameter int MAX_FRAME_BYTES = eirc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = eirc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eirc_pkg::CFG_AW-1:0]  paddr,
  input  logic [eirc_pkg::CFG_DW-1:0]  pwdata,
  output logic [eirc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  eirc_in_if.sink                      in_ch,
  eirc_out_if.source                   out_ch
);
  import eirc_pkg::*;

  cfg_t       cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  frame_sum_t q_wdata;
  frame_sum_t q_head;

  eirc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eirc_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  eirc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  eirc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .own_ip  (cfg.own_ip),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/eirc_cfg_regs.sv
// ----------------------------------------------------------------------------
// eirc_cfg_regs
// APB-style register file: own MAC, own IP and interface enable.
// ----------------------------------------------------------------------------
module eirc_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eirc_pkg::CFG_AW-1:0]  paddr,
  input  logic [eirc_pkg::CFG_DW-1:0]  pwdata,
  output logic [eirc_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output eirc_pkg::cfg_t               cfg
);
  import eirc_pkg::*;

  logic [47:0] own_mac_r, own_mac_nxt;
  logic [31:0] own_ip_r, own_ip_nxt;
  logic        if_enable_r, if_enable_nxt;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    own_mac_nxt   = own_mac_r;
    own_ip_nxt    = own_ip_r;
    if_enable_nxt = if_enable_r;
    if (wr_en) begin
      case (reg_idx)
        REG_OWN_MAC:   own_mac_nxt   = pwdata[47:0];
        REG_OWN_IP:    own_ip_nxt    = pwdata[31:0];
        REG_IF_ENABLE: if_enable_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_MAC:   prdata = {16'd0, own_mac_r};
      REG_OWN_IP:    prdata = {32'd0, own_ip_r};
      REG_IF_ENABLE: prdata = {63'd0, if_enable_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      own_ip_r    <= '0;
      if_enable_r <= 1'b0;
    end else begin
      own_mac_r   <= own_mac_nxt;
      own_ip_r    <= own_ip_nxt;
      if_enable_r <= if_enable_nxt;
    end
  end

  assign cfg.own_mac   = own_mac_r;
  assign cfg.own_ip    = own_ip_r;
  assign cfg.if_enable = if_enable_r;

endmodule

>>> rtl/eirc_front.sv
// ----------------------------------------------------------------------------
// eirc_front
// Byte parser: tracks frame position, captures header fields, folds the
// IPv4 header checksum and pushes one frame summary per last byte while enabled.
// ----------------------------------------------------------------------------
module eirc_front #(
  parameter int MAX_FRAME_BYTES = eirc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  eirc_in_if.sink              in_ch,
  input  eirc_pkg::cfg_t       cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output eirc_pkg::frame_sum_t q_data
);
  import eirc_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [CNT_W-1:0] cnt_r, cnt_upd;
  logic             mac_ours_r, mac_ours_upd;
  logic             mac_bcast_r, mac_bcast_upd;
  logic [15:0]      ftype_r, ftype_upd;
  logic [47:0]      smac_r, smac_upd;
  logic [7:0]       vihl_r, vihl_upd;
  logic [15:0]      tlen_r, tlen_upd;
  logic [15:0]      csum_r, csum_upd;
  logic [7:0]       held_r, held_upd;
  logic [31:0]      dip_r, dip_upd;
  logic [31:0]      sip_r, sip_upd;
  logic [7:0]       proto_r, proto_upd;

  logic             accept;
  logic             take;
  logic [7:0]       b;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] ip_pos;
  logic [5:0]       hlen;
  logic [7:0]       mine;
  logic [16:0]      csum_add;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.frame_byte;
  assign pos         = cnt_r;
  assign take        = cnt_r < CNT_W'(MAX_FRAME_BYTES);
  assign ip_pos      = cnt_r - CNT_W'(ETH_HDR);
  assign hlen        = {vihl_r[3:0], 2'b00};
  assign csum_add    = {1'b0, csum_r} + {1'b0, held_r, b};

  always_comb begin
    case (pos[2:0])
      3'd0:    mine = cfg.own_mac[47:40];
      3'd1:    mine = cfg.own_mac[39:32];
      3'd2:    mine = cfg.own_mac[31:24];
      3'd3:    mine = cfg.own_mac[23:16];
      3'd4:    mine = cfg.own_mac[15:8];
      default: mine = cfg.own_mac[7:0];
    endcase
  end

  always_comb begin
    cnt_upd       = cnt_r;
    mac_ours_upd  = mac_ours_r;
    mac_bcast_upd = mac_bcast_r;
    ftype_upd     = ftype_r;
    smac_upd      = smac_r;
    vihl_upd      = vihl_r;
    tlen_upd      = tlen_r;
    csum_upd      = csum_r;
    held_upd      = held_r;
    dip_upd       = dip_r;
    sip_upd       = sip_r;
    proto_upd     = proto_r;
    if (take) begin
      cnt_upd = cnt_r + 1'b1;
      if (pos < CNT_W'(6)) begin
        if (b != mine)      mac_ours_upd  = 1'b0;
        if (b != BYTE_ONES) mac_bcast_upd = 1'b0;
      end else if (pos < CNT_W'(12)) begin
        smac_upd = {smac_r[39:0], b};
      end else if (pos < CNT_W'(ETH_HDR)) begin
        ftype_upd = {ftype_r[7:0], b};
      end else begin
        if (ip_pos == CNT_W'(0)) begin
          vihl_upd = b;
        end else if (ip_pos == CNT_W'(2) || ip_pos == CNT_W'(3)) begin
          tlen_upd = {tlen_r[7:0], b};
        end else if (ip_pos == CNT_W'(9)) begin
          proto_upd = b;
        end else if (ip_pos >= CNT_W'(12) && ip_pos < CNT_W'(16)) begin
          sip_upd = {sip_r[23:0], b};
        end else if (ip_pos >= CNT_W'(16) && ip_pos < CNT_W'(IP_MIN_HDR)) begin
          dip_upd = {dip_r[23:0], b};
        end
        if (!ip_pos[0]) begin
          held_upd = b;
        end else if (ip_pos < {{(CNT_W-6){1'b0}}, hlen}) begin
          csum_upd = csum_add[15:0] + {15'd0, csum_add[16]};
        end
      end
    end
  end

  assign q_push = accept && cfg.if_enable && in_ch.end_of_frame;

  always_comb begin
    q_data.short_frame = cnt_upd < CNT_W'(ETH_HDR);
    q_data.byte_cnt    = FLEN_W'(cnt_upd);
    q_data.ip_len      = IPLEN_W'(cnt_upd - CNT_W'(ETH_HDR));
    q_data.mac_ok      = mac_ours_upd || mac_bcast_upd;
    q_data.frame_type  = ftype_upd;
    q_data.src_mac     = smac_upd;
    q_data.version_ihl = vihl_upd;
    q_data.ip_tot_len  = tlen_upd;
    q_data.csum        = csum_upd;
    q_data.dst_ip      = dip_upd;
    q_data.src_ip      = sip_upd;
    q_data.protocol    = proto_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && (!cfg.if_enable || in_ch.end_of_frame))) begin
      cnt_r       <= '0;
      mac_ours_r  <= 1'b1;
      mac_bcast_r <= 1'b1;
      ftype_r     <= '0;
      smac_r      <= '0;
      vihl_r      <= '0;
      tlen_r      <= '0;
      csum_r      <= '0;
      held_r      <= '0;
      dip_r       <= '0;
      sip_r       <= '0;
      proto_r     <= '0;
    end else if (accept) begin
      cnt_r       <= cnt_upd;
      mac_ours_r  <= mac_ours_upd;
      mac_bcast_r <= mac_bcast_upd;
      ftype_r     <= ftype_upd;
      smac_r      <= smac_upd;
      vihl_r      <= vihl_upd;
      tlen_r      <= tlen_upd;
      csum_r      <= csum_upd;
      held_r      <= held_upd;
      dip_r       <= dip_upd;
      sip_r       <= sip_upd;
      proto_r     <= proto_upd;
    end
  end

endmodule

>>> rtl/eirc_queue.sv
// ----------------------------------------------------------------------------
// eirc_queue
// Short register queue of frame summaries between parser and verdict stage.
// ----------------------------------------------------------------------------
module eirc_queue #(
  parameter int DEPTH = eirc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  eirc_pkg::frame_sum_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output eirc_pkg::frame_sum_t head
);
  import eirc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_sum_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = count_r == CNT_W'(DEPTH);
  assign valid = count_r != '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

>>> rtl/eirc_back.sv
// ----------------------------------------------------------------------------
// eirc_back
// Verdict stage: judges the queued frame summary and holds the result in
// the output register until the sink takes it.
// ----------------------------------------------------------------------------
module eirc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  eirc_pkg::frame_sum_t q_head,
  output logic                 q_pop,
  input  logic [31:0]          own_ip,
  eirc_out_if.source           out_ch
);
  import eirc_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  verdict_t            verdict_r, verdict_c;
  logic                learn_r, learn_c;
  logic [31:0]         sip_r, sip_c;
  logic [47:0]         smac_r, smac_c;
  logic [POFF_W-1:0]   poff_r, poff_c;
  logic [PLEN_W-1:0]   plen_r, plen_c;
  logic [FLEN_W-1:0]   flen_r;

  logic [5:0]          hlen;
  logic [IPLEN_W-1:0]  hlen_w;
  logic                load;

  assign hlen   = {q_head.version_ihl[3:0], 2'b00};
  assign hlen_w = IPLEN_W'(hlen);
  assign load   = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop  = load;

  always_comb begin
    verdict_c = V_SHORT;
    learn_c   = 1'b0;
    sip_c     = '0;
    smac_c    = '0;
    poff_c    = '0;
    plen_c    = '0;
    if (!q_head.short_frame) begin
      smac_c = q_head.src_mac;
      if (!q_head.mac_ok) begin
        verdict_c = V_MAC_MISS;
      end else if (q_head.frame_type == ETYPE_ARP) begin
        verdict_c = V_ARP;
      end else if (q_head.frame_type != ETYPE_IPV4) begin
        verdict_c = V_OTHER_TYPE;
      end else begin
        if (q_head.ip_len >= IPLEN_W'(IP_MIN_HDR)) begin
          learn_c = 1'b1;
          sip_c   = q_head.src_ip;
        end
        if (q_head.ip_len < IPLEN_W'(IP_MIN_HDR)) begin
          verdict_c = V_BAD_HLEN;
        end else if (q_head.version_ihl[7:4] != IP_VERSION4) begin
          verdict_c = V_BAD_VERSION;
        end else if (hlen < 6'(IP_MIN_HDR) || hlen_w > q_head.ip_len) begin
          verdict_c = V_BAD_HLEN;
        end else if (q_head.ip_tot_len > q_head.ip_len || q_head.ip_tot_len < hlen_w) begin
          verdict_c = V_BAD_TLEN;
        end else if (q_head.csum != CSUM_GOOD) begin
          verdict_c = V_BAD_CSUM;
        end else if (q_head.dst_ip != own_ip && q_head.dst_ip != IP_BCAST &&
                     own_ip != '0) begin
          verdict_c = V_NOT_OURS;
        end else begin
          case (q_head.protocol)
            PROTO_ICMP: verdict_c = V_ICMP;
            PROTO_UDP:  verdict_c = V_UDP;
            PROTO_TCP:  verdict_c = V_TCP;
            default:    verdict_c = V_UNKNOWN;
          endcase
          poff_c = POFF_W'(ETH_HDR) + POFF_W'(hlen);
          plen_c = PLEN_W'(q_head.ip_tot_len - hlen_w);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict_r <= verdict_c;
      learn_r   <= learn_c;
      sip_r     <= sip_c;
      smac_r    <= smac_c;
      poff_r    <= poff_c;
      plen_r    <= plen_c;
      flen_r    <= q_head.byte_cnt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.learn_valid    = learn_r;
  assign out_ch.source_ip      = sip_r;
  assign out_ch.source_mac     = smac_r;
  assign out_ch.payload_offset = poff_r;
  assign out_ch.payload_length = plen_r;
  assign out_ch.frame_length   = flen_r;

  a_poff_only_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && poff_r != '0) |->
      (verdict_r == V_ICMP || verdict_r == V_UDP || verdict_r == V_TCP ||
       verdict_r == V_UNKNOWN))
    else $error("payload offset on a rejected frame");

  a_learn_only_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && learn_r) |->
      (verdict_r != V_SHORT && verdict_r != V_MAC_MISS && verdict_r != V_ARP &&
       verdict_r != V_OTHER_TYPE))
    else $error("learn flagged on a non-IPv4 frame");

  a_short_no_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && verdict_r == V_SHORT) |-> (smac_r == '0 && !learn_r))
    else $error("short frame carries source fields");

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for eth_ipv4_rx_classifier_unit. Frames go in one byte
// per transaction. A byte-level predictor computes the verdict of each frame,
// and every verdict transaction is compared field by field in arrival order.
// Traffic: directed frames for every verdict and length corner, then random
// well-formed IPv4 frames mixed with broken ones, under several station
// settings and with the interface disabled. Both channels stall at random,
// with one long hold on the verdict side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import eirc_pkg::*;

  localparam int FRAME_CAP      = MAX_FRAME_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int IDLE_PCT       = 22;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } rx_beat_t;

  typedef struct packed {
    verdict_t          verdict;
    logic              learn;
    logic [31:0]       src_ip;
    logic [47:0]       src_mac;
    logic [POFF_W-1:0] poff;
    logic [PLEN_W-1:0] plen;
    logic [FLEN_W-1:0] flen;
  } frame_verdict_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  eirc_in_if  in_if ();
  eirc_out_if out_if ();

  eth_ipv4_rx_classifier_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_if),
    .out_ch  (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [47:0] own_mac_q = '0;
  logic [31:0] own_ip_q  = '0;
  logic        if_en_q   = 1'b0;

  int          rx_count;
  logic        dmac_mine;
  logic        dmac_bcast;
  logic [15:0] etype_acc;
  logic [47:0] smac_acc;
  logic [7:0]  ver_ihl_acc;
  logic [15:0] tlen_acc;
  logic [15:0] csum_acc;
  logic [7:0]  hi_byte;
  logic [31:0] dip_acc;
  logic [31:0] sip_acc;
  logic [7:0]  proto_acc;

  rx_beat_t       beats_q[$];
  frame_verdict_t verdict_q[$];
  logic [7:0]     fbuf[$];
  rx_beat_t       next_beat;

  int beats_pushed = 0;
  int beats_taken  = 0;
  int errors       = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;
  bit hold_tog     = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;

  task clear_rx_state();
    rx_count    = 0;
    dmac_mine   = 1'b1;
    dmac_bcast  = 1'b1;
    etype_acc   = '0;
    smac_acc    = '0;
    ver_ihl_acc = '0;
    tlen_acc    = '0;
    csum_acc    = '0;
    hi_byte     = '0;
    dip_acc     = '0;
    sip_acc     = '0;
    proto_acc   = '0;
  endtask

  task absorb_byte(input logic [7:0] b);
    int          i;
    int          hl;
    logic [16:0] s;
    if (rx_count < 6) begin
      if (b != own_mac_q[8*(5-rx_count) +: 8]) dmac_mine = 1'b0;
      if (b != BYTE_ONES) dmac_bcast = 1'b0;
    end else if (rx_count < 12) begin
      smac_acc = {smac_acc[39:0], b};
    end else if (rx_count < ETH_HDR) begin
      etype_acc = {etype_acc[7:0], b};
    end else begin
      i  = rx_count - ETH_HDR;
      hl = ver_ihl_acc[3:0] * 4;
      if (i == 0) ver_ihl_acc = b;
      else if (i == 2 || i == 3) tlen_acc = {tlen_acc[7:0], b};
      else if (i == 9) proto_acc = b;
      else if (i >= 12 && i < 16) sip_acc = {sip_acc[23:0], b};
      else if (i >= 16 && i < 20) dip_acc = {dip_acc[23:0], b};
      if (i[0] == 1'b0) begin
        hi_byte = b;
      end else if (i < hl) begin
        s        = {1'b0, csum_acc} + {1'b0, hi_byte, b};
        csum_acc = s[15:0] + s[16];
      end
    end
  endtask

  task take_beat(input rx_beat_t beat);
    frame_verdict_t v;
    int             ip_len;
    int             hl;
    int             tl;
    if (!if_en_q) begin
      clear_rx_state();
      return;
    end
    if (rx_count < FRAME_CAP) begin
      absorb_byte(beat.data);
      rx_count++;
    end
    if (!beat.eof) return;
    v         = '0;
    v.verdict = V_SHORT;
    hl        = ver_ihl_acc[3:0] * 4;
    tl        = tlen_acc;
    if (rx_count >= ETH_HDR) begin
      v.src_mac = smac_acc;
      ip_len    = rx_count - ETH_HDR;
      if (!dmac_mine && !dmac_bcast) begin
        v.verdict = V_MAC_MISS;
      end else if (etype_acc == ETYPE_ARP) begin
        v.verdict = V_ARP;
      end else if (etype_acc != ETYPE_IPV4) begin
        v.verdict = V_OTHER_TYPE;
      end else begin
        if (ip_len >= IP_MIN_HDR) begin
          v.learn  = 1'b1;
          v.src_ip = sip_acc;
        end
        if (ip_len < IP_MIN_HDR) v.verdict = V_BAD_HLEN;
        else if (ver_ihl_acc[7:4] != IP_VERSION4) v.verdict = V_BAD_VERSION;
        else if (hl < IP_MIN_HDR || hl > ip_len) v.verdict = V_BAD_HLEN;
        else if (tl > ip_len || tl < hl) v.verdict = V_BAD_TLEN;
        else if (csum_acc != CSUM_GOOD) v.verdict = V_BAD_CSUM;
        else if (dip_acc != own_ip_q && dip_acc != IP_BCAST && own_ip_q != '0) begin
          v.verdict = V_NOT_OURS;
        end else begin
          case (proto_acc)
            PROTO_ICMP: v.verdict = V_ICMP;
            PROTO_UDP:  v.verdict = V_UDP;
            PROTO_TCP:  v.verdict = V_TCP;
            default:    v.verdict = V_UNKNOWN;
          endcase
          v.poff = POFF_W'(ETH_HDR + hl);
          v.plen = PLEN_W'(tl - hl);
        end
      end
    end
    v.flen = FLEN_W'(rx_count);
    verdict_q.push_back(v);
    clear_rx_state();
  endtask

  function void match_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task check_verdict();
    frame_verdict_t want;
    if (verdict_q.size() == 0) begin
      $error("verdict: expected none, got %0d", out_if.verdict);
      errors++;
      return;
    end
    want = verdict_q.pop_front();
    match_field("verdict", want.verdict, out_if.verdict);
    match_field("learn_valid", want.learn, out_if.learn_valid);
    match_field("source_ip", want.src_ip, out_if.source_ip);
    match_field("source_mac", want.src_mac, out_if.source_mac);
    match_field("payload_offset", want.poff, out_if.payload_offset);
    match_field("payload_length", want.plen, out_if.payload_length);
    match_field("frame_length", want.flen, out_if.frame_length);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) check_verdict();
      if (in_if.valid && in_if.ready) begin
        take_beat({in_if.frame_byte, in_if.end_of_frame});
        beats_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (beats_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_beat          = beats_q.pop_front();
        in_if.valid        <= 1'b1;
        in_if.frame_byte   <= next_beat.data;
        in_if.end_of_frame <= next_beat.eof;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen    <= hold_tog;
      hold_left    <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** eth_ipv4_rx_classifier_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task reg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_OWN_MAC:   own_mac_q = value[47:0];
      REG_OWN_IP:    own_ip_q  = value[31:0];
      REG_IF_ENABLE: if_en_q   = value[0];
      default: ;
    endcase
  endtask

  task drain_and_settle();
    while (beats_taken != beats_pushed || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task send_frame(input bit terminate);
    for (int k = 0; k < fbuf.size(); k++) begin
      beats_q.push_back({fbuf[k], terminate && (k == fbuf.size() - 1)});
      beats_pushed++;
    end
    fbuf.delete();
  endtask

  function logic [15:0] header_sum(input int hl);
    int acc;
    acc = 0;
    for (int k = 0; k < hl; k += 2) begin
      acc = acc + {fbuf[ETH_HDR + k], fbuf[ETH_HDR + k + 1]};
      acc = (acc & 'hFFFF) + (acc >> 16);
    end
    return acc[15:0];
  endfunction

  task build_ipv4(input logic [47:0] dmac, input logic [3:0] ver, input logic [3:0] ihl,
                  input int tlen, input logic [7:0] proto, input logic [31:0] dip,
                  input bit csum_ok, input int nbytes);
    int          hl;
    int          hdr;
    logic [15:0] csum;
    hl  = ihl * 4;
    hdr = (hl < IP_MIN_HDR) ? IP_MIN_HDR : hl;
    fbuf.delete();
    for (int k = 0; k < 6; k++) fbuf.push_back(dmac[8*(5-k) +: 8]);
    repeat (6) fbuf.push_back(8'($urandom));
    fbuf.push_back(ETYPE_IPV4[15:8]);
    fbuf.push_back(ETYPE_IPV4[7:0]);
    fbuf.push_back({ver, ihl});
    fbuf.push_back(8'($urandom));
    fbuf.push_back(tlen[15:8]);
    fbuf.push_back(tlen[7:0]);
    repeat (5) fbuf.push_back(8'($urandom));
    fbuf.push_back(proto);
    fbuf.push_back(8'h00);
    fbuf.push_back(8'h00);
    repeat (4) fbuf.push_back(8'($urandom));
    for (int k = 0; k < 4; k++) fbuf.push_back(dip[8*(3-k) +: 8]);
    while (fbuf.size() < ETH_HDR + hdr || fbuf.size() < nbytes) fbuf.push_back(8'($urandom));
    if (hl >= IP_MIN_HDR) begin
      csum = ~header_sum(hl);
      if (!csum_ok) csum = csum ^ 16'($urandom_range(1, 65535));
      fbuf[ETH_HDR + 10] = csum[15:8];
      fbuf[ETH_HDR + 11] = csum[7:0];
    end
    while (fbuf.size() > nbytes) void'(fbuf.pop_back());
  endtask

  task offer_ipv4(input logic [47:0] dmac, input logic [3:0] ver, input logic [3:0] ihl,
                  input int tlen, input logic [7:0] proto, input logic [31:0] dip,
                  input bit csum_ok, input int nbytes);
    build_ipv4(dmac, ver, ihl, tlen, proto, dip, csum_ok, nbytes);
    send_frame(1'b1);
  endtask

  task random_frame();
    logic [47:0] dmac;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] dip;
    bit          good;
    int          hl;
    int          tlen;
    int          nbytes;
    int          pick;
    dmac = ($urandom_range(0, 3) == 0) ? 48'hFFFF_FFFF_FFFF : own_mac_q;
    ver  = IP_VERSION4;
    ihl  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    case ($urandom_range(0, 3))
      0:       proto = PROTO_ICMP;
      1:       proto = PROTO_UDP;
      2:       proto = PROTO_TCP;
      default: proto = 8'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    dip  = (pick < 50) ? own_ip_q : (pick < 65) ? IP_BCAST : 32'($urandom);
    good = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick >= 74 && pick < 77) ver = 4'($urandom);
    if (pick >= 77 && pick < 80) ihl = 4'($urandom_range(0, 4));
    if (pick >= 89 && pick < 94) good = 1'b0;
    if (pick >= 97) dip = $urandom;
    if (pick >= 64 && pick < 68) dmac = own_mac_q ^ (48'h1 << $urandom_range(0, 47));
    hl     = ihl * 4;
    tlen   = hl + $urandom_range(0, 40);
    nbytes = ETH_HDR + tlen + $urandom_range(0, 8);
    if (pick >= 60 && pick < 64) nbytes = $urandom_range(1, ETH_HDR - 1);
    if (pick >= 80 && pick < 83) nbytes = ETH_HDR + $urandom_range(0, hl - 1);
    if (pick >= 83 && pick < 86) tlen = $urandom_range(nbytes - ETH_HDR + 1, 65535);
    if (pick >= 86 && pick < 89) tlen = $urandom_range(0, hl - 1);
    build_ipv4(dmac, ver, ihl, tlen, proto, dip, good, nbytes);
    if (pick >= 68 && pick < 71) fbuf[13] = ETYPE_ARP[7:0];
    if (pick >= 71 && pick < 74) begin
      fbuf[12] = 8'($urandom);
      fbuf[13] = 8'($urandom);
    end
    if (pick >= 94 && pick < 97) begin
      for (int k = ETH_HDR; k < fbuf.size(); k++) fbuf[k] = 8'($urandom);
    end
    send_frame(1'b1);
  endtask

  task random_traffic(input int budget);
    int start;
    start = beats_pushed;
    while (beats_pushed - start < budget) random_frame();
  endtask

  task directed_frames();
    logic [47:0] m;
    logic [31:0] ip;
    m  = own_mac_q;
    ip = own_ip_q;
    offer_ipv4(m, IP_VERSION4, 4'd5, 20, PROTO_ICMP, ip, 1'b1, 1);
    offer_ipv4(m, IP_VERSION4, 4'd5, 20, PROTO_ICMP, ip, 1'b1, ETH_HDR - 1);
    offer_ipv4(m, IP_VERSION4, 4'd5, 20, PROTO_ICMP, ip, 1'b1, ETH_HDR);
    offer_ipv4(m, IP_VERSION4, 4'd5, 20, PROTO_ICMP, ip, 1'b1, ETH_HDR + IP_MIN_HDR - 1);
    offer_ipv4(~m, IP_VERSION4, 4'd5, 20, PROTO_UDP, ip, 1'b1, 60);
    build_ipv4(48'hFFFF_FFFF_FFFF, IP_VERSION4, 4'd5, 28, PROTO_UDP, ip, 1'b1, 60);
    fbuf[13] = ETYPE_ARP[7:0];
    send_frame(1'b1);
    build_ipv4(m, IP_VERSION4, 4'd5, 28, PROTO_UDP, ip, 1'b1, 60);
    fbuf[12] = 8'hFF;
    fbuf[13] = 8'hFF;
    send_frame(1'b1);
    offer_ipv4(m, 4'd6, 4'd5, 20, PROTO_TCP, ip, 1'b1, 34);
    offer_ipv4(m, IP_VERSION4, 4'd4, 20, PROTO_TCP, ip, 1'b1, 34);
    offer_ipv4(m, IP_VERSION4, 4'd15, 60, PROTO_TCP, ip, 1'b1, ETH_HDR + 40);
    offer_ipv4(m, IP_VERSION4, 4'd5, 16'hFFFF, PROTO_TCP, ip, 1'b1, 60);
    offer_ipv4(m, IP_VERSION4, 4'd5, 19, PROTO_TCP, ip, 1'b1, 60);
    offer_ipv4(m, IP_VERSION4, 4'd5, 30, PROTO_TCP, ip, 1'b0, 60);
    offer_ipv4(m, IP_VERSION4, 4'd5, 30, PROTO_TCP, ~ip, 1'b1, 60);
    offer_ipv4(m, IP_VERSION4, 4'd5, 20, PROTO_ICMP, ip, 1'b1, 34);
    offer_ipv4(48'hFFFF_FFFF_FFFF, IP_VERSION4, 4'd15, 90, PROTO_UDP, IP_BCAST, 1'b1, 104);
    offer_ipv4(m, IP_VERSION4, 4'd5, 46, PROTO_TCP, ip, 1'b1, 64);
    offer_ipv4(m, IP_VERSION4, 4'd5, 26, 8'hFF, ip, 1'b1, 40);
    offer_ipv4(m, IP_VERSION4, 4'd6, 30, 8'h00, ip, 1'b1, 44);
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.frame_byte   = '0;
    in_if.end_of_frame = 1'b0;
    out_if.ready       = 1'b0;
    clear_rx_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    random_frame();
    random_frame();
    drain_and_settle();

    reg_write(REG_OWN_MAC, {$urandom, $urandom});
    reg_write(REG_OWN_IP, {$urandom, $urandom});
    reg_write(REG_IF_ENABLE, 64'd1);
    directed_frames();
    drain_and_settle();
    random_traffic(160);
    drain_and_settle();

    build_ipv4(own_mac_q, IP_VERSION4, 4'd5, 26, PROTO_UDP, own_ip_q, 1'b1, 40);
    send_frame(1'b0);
    drain_and_settle();
    reg_write(REG_IF_ENABLE, 64'd0);
    repeat (3) fbuf.push_back(8'($urandom));
    send_frame(1'b1);
    drain_and_settle();
    reg_write(REG_IF_ENABLE, 64'd1);
    offer_ipv4(own_mac_q, IP_VERSION4, 4'd5, 26, PROTO_UDP, own_ip_q, 1'b1, 40);
    drain_and_settle();

    reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_OWN_IP, 64'hFFFF_FFFF_FFFF_FFFF);
    no_idle = 1'b1;
    random_traffic(120);
    drain_and_settle();
    no_idle = 1'b0;

    reg_write(REG_OWN_MAC, 64'd0);
    reg_write(REG_OWN_IP, 64'd0);
    random_traffic(120);
    drain_and_settle();

    hold_tog = ~hold_tog;
    repeat (40) begin
      fbuf.push_back(8'($urandom));
      send_frame(1'b1);
    end
    drain_and_settle();

    reg_write(REG_OWN_MAC, {$urandom, $urandom});
    reg_write(REG_OWN_IP, {$urandom, $urandom});
    random_traffic(100);
    drain_and_settle();

    if (errors == 0 && verdict_q.size() == 0) begin
      $display("** eth_ipv4_rx_classifier_unit: PASSED **");
    end else begin
      $display("** eth_ipv4_rx_classifier_unit: FAILED **");
    end
    $finish;
  end

endmodule
